@@ sv/sphd_pkg.sv @@
`timescale 1ns / 1ps
// sphd_pkg: widths, constants and shared types for the spectrum peak hold block
// no dependencies; used by every other file of the block

package sphd_pkg;

    // frame geometry
    localparam int BINS  = 1024;
    localparam int BIN_W = $clog2(BINS);
    localparam int HALF  = BINS / 2;

    // field widths
    localparam int IN_W  = 24;
    localparam int POW_W = 48;
    localparam int COL_W = 10;
    localparam int LVL_W = 13;
    localparam int FPR_W = 16;

    // log2 datapath
    localparam int E_W      = $clog2(POW_W);
    localparam int LOG_FRAC = 16;
    localparam int ROUNDS   = LOG_FRAC;
    localparam int M_W      = 31;
    localparam int LOG_W    = E_W + LOG_FRAC;
    localparam int D_W      = LOG_W + 1;
    localparam int LOG_K    = 3156542;
    localparam int K_W      = $clog2(LOG_K + 1);
    localparam int P_W      = D_W + K_W + 1;
    localparam int RND_SH   = 32;
    localparam int R_W      = P_W - RND_SH;

    localparam int LEVEL_MIN = -3200;
    localparam int LEVEL_MAX = 2400;

    // column that carries the last bin of a frame
    localparam int LAST_BIN_COL = (BINS % 2 == 1) ? BINS - 1 : BINS - 1 - HALF;

    // log2 in Q.16, evaluated at elaboration for the normalization term
    function automatic int unsigned log2_q16_const(input longint unsigned x);
        int unsigned       e;
        longint unsigned   m;
        int unsigned       frac;
        e    = 0;
        frac = 0;
        for (int b = 0; b < 63; b++) begin
            if ((x >> (b + 1)) != 0) begin
                e = b + 1;
            end
        end
        if (e > 30) begin
            m = x >> (e - 30);
        end else begin
            m = x << (30 - e);
        end
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 1;
            end
        end
        return (e << 16) | frac;
    endfunction

    localparam int LOG_BINS2 = 2 * int'(log2_q16_const(longint'(BINS)));

    // result routing that travels alongside the level computation
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             row_done;
    } t_tag;

endpackage

@@ sv/sphd_if.sv @@
`timescale 1ns / 1ps
// sphd_in_if / sphd_out_if: valid-ready channels for bins in and levels out
// depends on sphd_pkg for field widths

interface sphd_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sphd_pkg::IN_W-1:0]  bin_real;
    logic signed [sphd_pkg::IN_W-1:0]  bin_imag;

    modport source (output valid, output bin_real, output bin_imag, input ready);
    modport sink   (input valid, input bin_real, input bin_imag, output ready);
endinterface

interface sphd_out_if;
    logic                              valid;
    logic                              ready;
    logic        [sphd_pkg::COL_W-1:0] column;
    logic signed [sphd_pkg::LVL_W-1:0] level;
    logic                              row_done;

    modport source (output valid, output column, output level, output row_done, input ready);
    modport sink   (input valid, input column, input level, input row_done, output ready);
endinterface

@@ sv/sphd_log_level.sv @@
`timescale 1ns / 1ps
// sphd_log_level: pipelined power to 1/16 dB level conversion (log2 by squaring)
// depends on sphd_pkg; 20 register stages, all advancing on i_en

module sphd_log_level (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [sphd_pkg::POW_W-1:0]        i_peak,
    input  sphd_pkg::t_tag                    i_tag,
    output logic                              o_valid,
    output logic signed [sphd_pkg::LVL_W-1:0] o_level,
    output sphd_pkg::t_tag                    o_tag
);

    // stage 0: top set bit
    logic [sphd_pkg::E_W-1:0]   w_e;
    logic                       r0_v;
    logic [sphd_pkg::POW_W-1:0] r0_peak;
    logic [sphd_pkg::E_W-1:0]   r0_e;
    logic                       r0_z;
    sphd_pkg::t_tag             r0_tag;

    always_comb begin
        w_e = '0;
        for (int b = 0; b < sphd_pkg::POW_W; b++) begin
            if (i_peak[b]) begin
                w_e = sphd_pkg::E_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_peak <= i_peak;
            r0_e    <= w_e;
            r0_z    <= (i_peak == '0);
            r0_tag  <= i_tag;
        end
    end

    // stage 1: normalize mantissa to q30, then the squaring rounds
    logic [sphd_pkg::POW_W-1:0]    w_norm;
    logic [sphd_pkg::M_W-1:0]      r_m   [0:sphd_pkg::ROUNDS];
    logic [sphd_pkg::LOG_FRAC-1:0] r_fr  [0:sphd_pkg::ROUNDS];
    logic [sphd_pkg::E_W-1:0]      r_e   [0:sphd_pkg::ROUNDS];
    logic                          r_z   [0:sphd_pkg::ROUNDS];
    sphd_pkg::t_tag                r_tag [0:sphd_pkg::ROUNDS];
    logic                          r_v   [0:sphd_pkg::ROUNDS];

    assign w_norm = r0_peak << (sphd_pkg::E_W'(sphd_pkg::POW_W - 1) - r0_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]   <= w_norm[sphd_pkg::POW_W-1 -: sphd_pkg::M_W];
            r_fr[0]  <= '0;
            r_e[0]   <= r0_e;
            r_z[0]   <= r0_z;
            r_tag[0] <= r0_tag;
        end
    end

    for (genvar k = 0; k < sphd_pkg::ROUNDS; k++) begin : g_round
        logic [2*sphd_pkg::M_W-1:0] w_sq;
        logic [sphd_pkg::M_W:0]     w_s;

        // m*m >> 30, one fraction bit per round
        assign w_sq = r_m[k] * r_m[k];
        assign w_s  = w_sq[2*sphd_pkg::M_W-1 -: sphd_pkg::M_W+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k+1]   <= w_s[sphd_pkg::M_W] ? w_s[sphd_pkg::M_W:1]
                                                 : w_s[sphd_pkg::M_W-1:0];
                r_fr[k+1]  <= {r_fr[k][sphd_pkg::LOG_FRAC-2:0], w_s[sphd_pkg::M_W]};
                r_e[k+1]   <= r_e[k];
                r_z[k+1]   <= r_z[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    // final stage 1: subtract normalization, scale to 1/16 dB
    logic [sphd_pkg::LOG_W-1:0]      w_l;
    logic signed [sphd_pkg::D_W-1:0] w_d;
    logic signed [sphd_pkg::P_W-1:0] w_prod;
    logic                            rf1_v;
    logic                            rf1_z;
    logic signed [sphd_pkg::P_W-1:0] rf1_prod;
    sphd_pkg::t_tag                  rf1_tag;

    assign w_l    = {r_e[sphd_pkg::ROUNDS], r_fr[sphd_pkg::ROUNDS]};
    assign w_d    = $signed({1'b0, w_l}) - $signed(sphd_pkg::D_W'(sphd_pkg::LOG_BINS2));
    assign w_prod = w_d * $signed({1'b0, sphd_pkg::K_W'(sphd_pkg::LOG_K)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf1_v <= 1'b0;
        end else if (i_en) begin
            rf1_v <= r_v[sphd_pkg::ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rf1_prod <= w_prod;
            rf1_z    <= r_z[sphd_pkg::ROUNDS];
            rf1_tag  <= r_tag[sphd_pkg::ROUNDS];
        end
    end

    // final stage 2: round half away from zero, clamp, zero-power floor
    logic                            w_neg;
    logic [sphd_pkg::P_W-1:0]        w_mag;
    logic [sphd_pkg::P_W-1:0]        w_rnd;
    logic [sphd_pkg::R_W-1:0]        w_r;
    logic signed [sphd_pkg::R_W:0]   w_raw;
    logic signed [sphd_pkg::LVL_W-1:0] w_level;
    logic                            r_ov;
    logic signed [sphd_pkg::LVL_W-1:0] r_olevel;
    sphd_pkg::t_tag                  r_otag;

    assign w_neg = rf1_prod[sphd_pkg::P_W-1];
    assign w_mag = w_neg ? $unsigned(-rf1_prod) : $unsigned(rf1_prod);
    assign w_rnd = w_mag + (sphd_pkg::P_W'(1) << (sphd_pkg::RND_SH - 1));
    assign w_r   = w_rnd[sphd_pkg::P_W-1:sphd_pkg::RND_SH];
    assign w_raw = w_neg ? -$signed({1'b0, w_r}) : $signed({1'b0, w_r});

    always_comb begin
        if (rf1_z) begin
            w_level = sphd_pkg::LVL_W'(sphd_pkg::LEVEL_MIN);
        end else if (w_raw < $signed((sphd_pkg::R_W+1)'(sphd_pkg::LEVEL_MIN))) begin
            w_level = sphd_pkg::LVL_W'(sphd_pkg::LEVEL_MIN);
        end else if (w_raw > $signed((sphd_pkg::R_W+1)'(sphd_pkg::LEVEL_MAX))) begin
            w_level = sphd_pkg::LVL_W'(sphd_pkg::LEVEL_MAX);
        end else begin
            w_level = sphd_pkg::LVL_W'(w_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= rf1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_olevel <= w_level;
            r_otag   <= rf1_tag;
        end
    end

    assign o_valid = r_ov;
    assign o_level = r_olevel;
    assign o_tag   = r_otag;

endmodule

@@ sv/spectrum_peak_hold_db.sv @@
`timescale 1ns / 1ps
// spectrum_peak_hold_db: per-bin peak hold of fft power, reported in 1/16 dB
// depends on sphd_pkg, sphd_if (channels) and sphd_log_level
//
//   port       dir   kind        carries
//   i_bin      in    valid/ready bin_real, bin_imag (one fft bin per item)
//   o_res      out   valid/ready column, level, row_done (last frame of a row only)
//   i_cfg_*    in    write only  frames_per_row
//
// one item per cycle sustained while the skid register is empty; a result
// passes 3 front stages, 20 log stages set by 16 squaring rounds, output register
// reset clears counters, valid bits and sets frames_per_row to 1; the peak
// store is not cleared, the first frame of every row overwrites it
// a stalled output holds its item and a skid register takes one more, ready
// drops only while the skid register is full; the whole pipeline then holds

module spectrum_peak_hold_db (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sphd_pkg::FPR_W-1:0] i_cfg_data,
    sphd_in_if.sink                    i_bin,
    sphd_out_if.source                 o_res
);

    // configuration
    logic [sphd_pkg::FPR_W-1:0] r_fpr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpr <= sphd_pkg::FPR_W'(1);
        end else if (i_cfg_we) begin
            r_fpr <= i_cfg_data;
        end
    end

    // pipeline advance: everything moves unless the skid register holds an item
    logic r_skid_v;
    logic w_en;
    logic w_acc;

    assign w_en        = !r_skid_v;
    assign i_bin.ready = w_en;
    assign w_acc       = i_bin.valid && w_en;

    // bin and frame position
    logic [sphd_pkg::BIN_W-1:0] r_bin_cnt;
    logic [sphd_pkg::FPR_W-1:0] r_frame_cnt;
    logic [sphd_pkg::FPR_W-1:0] w_fpr_eff;
    logic                       w_last_frame;
    logic                       w_last_bin;

    // zero frames per row acts as one
    assign w_fpr_eff    = (r_fpr == '0) ? sphd_pkg::FPR_W'(1) : r_fpr;
    // at or past the end also counts, so lowering the count mid-row ends the row
    assign w_last_frame = ({1'b0, r_frame_cnt} + (sphd_pkg::FPR_W+1)'(1)) >= {1'b0, w_fpr_eff};
    assign w_last_bin   = (r_bin_cnt == sphd_pkg::BIN_W'(sphd_pkg::BINS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt   <= '0;
            r_frame_cnt <= '0;
        end else if (w_acc) begin
            if (w_last_bin) begin
                r_bin_cnt   <= '0;
                r_frame_cnt <= w_last_frame ? '0 : r_frame_cnt + sphd_pkg::FPR_W'(1);
            end else begin
                r_bin_cnt <= r_bin_cnt + sphd_pkg::BIN_W'(1);
            end
        end
    end

    // peak store, read at accept, written two stages later; the same bin comes
    // back only a whole frame later, so no forwarding is needed
    logic [sphd_pkg::POW_W-1:0] peak_mem [0:sphd_pkg::BINS-1];

    // stage 1: registered input and stored peak
    logic                        r1_v;
    logic signed [sphd_pkg::IN_W-1:0] r1_re;
    logic signed [sphd_pkg::IN_W-1:0] r1_im;
    logic [sphd_pkg::BIN_W-1:0]  r1_j;
    logic                        r1_first;
    logic                        r1_last_frame;
    logic                        r1_last_bin;
    logic [sphd_pkg::POW_W-1:0]  r1_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_re         <= i_bin.bin_real;
            r1_im         <= i_bin.bin_imag;
            r1_j          <= r_bin_cnt;
            r1_first      <= (r_frame_cnt == '0);
            r1_last_frame <= w_last_frame;
            r1_last_bin   <= w_last_bin;
            r1_old        <= peak_mem[r_bin_cnt];
        end
    end

    // stage 2: squares
    logic signed [2*sphd_pkg::IN_W-1:0] w_sq_re;
    logic signed [2*sphd_pkg::IN_W-1:0] w_sq_im;
    logic                        r2_v;
    logic [sphd_pkg::POW_W-1:0]  r2_sq_re;
    logic [sphd_pkg::POW_W-1:0]  r2_sq_im;
    logic [sphd_pkg::POW_W-1:0]  r2_old;
    logic [sphd_pkg::BIN_W-1:0]  r2_j;
    logic                        r2_first;
    logic                        r2_last_frame;
    logic                        r2_last_bin;

    assign w_sq_re = r1_re * r1_re;
    assign w_sq_im = r1_im * r1_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sq_re      <= sphd_pkg::POW_W'($unsigned(w_sq_re));
            r2_sq_im      <= sphd_pkg::POW_W'($unsigned(w_sq_im));
            r2_old        <= r1_old;
            r2_j          <= r1_j;
            r2_first      <= r1_first;
            r2_last_frame <= r1_last_frame;
            r2_last_bin   <= r1_last_bin;
        end
    end

    // stage 3: power, peak update, column swap
    logic [sphd_pkg::POW_W-1:0] w_pow;
    logic [sphd_pkg::POW_W-1:0] w_peak;
    logic [sphd_pkg::BIN_W:0]   w_col_full;
    sphd_pkg::t_tag             w_tag;
    logic                       r3_v;
    logic [sphd_pkg::POW_W-1:0] r3_peak;
    sphd_pkg::t_tag             r3_tag;

    assign w_pow  = r2_sq_re + r2_sq_im;
    // first frame of a row overwrites whatever the store holds
    assign w_peak = (r2_first || (w_pow > r2_old)) ? w_pow : r2_old;

    // fft shift: halves swapped, an odd last bin keeps its place
    always_comb begin
        if ({1'b0, r2_j} < (sphd_pkg::BIN_W+1)'(sphd_pkg::HALF)) begin
            w_col_full = {1'b0, r2_j} + (sphd_pkg::BIN_W+1)'(sphd_pkg::HALF);
        end else if ({1'b0, r2_j} < (sphd_pkg::BIN_W+1)'(2 * sphd_pkg::HALF)) begin
            w_col_full = {1'b0, r2_j} - (sphd_pkg::BIN_W+1)'(sphd_pkg::HALF);
        end else begin
            w_col_full = {1'b0, r2_j};
        end
    end

    assign w_tag = {sphd_pkg::COL_W'(w_col_full), r2_last_bin};

    always_ff @(posedge i_clk) begin
        if (w_en && r2_v) begin
            peak_mem[r2_j] <= w_peak;
        end
    end

    // only the last frame of a row goes on to the level pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v && r2_last_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_peak <= w_peak;
            r3_tag  <= w_tag;
        end
    end

    // level computation
    logic                              w_lv;
    logic signed [sphd_pkg::LVL_W-1:0] w_level;
    sphd_pkg::t_tag                    w_ltag;

    sphd_log_level u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_peak  (r3_peak),
        .i_tag   (r3_tag),
        .o_valid (w_lv),
        .o_level (w_level),
        .o_tag   (w_ltag)
    );

    // output register plus one skid register
    logic                              r_ov;
    logic signed [sphd_pkg::LVL_W-1:0] r_olevel;
    sphd_pkg::t_tag                    r_otag;
    logic signed [sphd_pkg::LVL_W-1:0] r_skid_level;
    sphd_pkg::t_tag                    r_skid_tag;
    logic                              w_out_free;
    logic                              w_arrive;

    assign w_out_free = !r_ov || o_res.ready;
    assign w_arrive   = w_en && w_lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            r_ov     <= r_skid_v || w_arrive;
            r_skid_v <= 1'b0;
        end else if (w_arrive) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_olevel <= r_skid_v ? r_skid_level : w_level;
            r_otag   <= r_skid_v ? r_skid_tag : w_ltag;
        end else if (w_arrive) begin
            r_skid_level <= w_level;
            r_skid_tag   <= w_ltag;
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.column   = r_otag.column;
    assign o_res.level    = r_olevel;
    assign o_res.row_done = r_otag.row_done;

endmodule

@@ sv/sphd_checker.sv @@
`timescale 1ns / 1ps
// sphd_checker: port-level assertions for spectrum_peak_hold_db
// depends on sphd_pkg; bound to the top level at the end of this file

module sphd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [sphd_pkg::COL_W-1:0]        i_column,
    input logic signed [sphd_pkg::LVL_W-1:0] i_level,
    input logic                              i_row_done
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_column) && $stable(i_level) && $stable(i_row_done))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // ready drops only after the output was stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input stalled without output back pressure");

    // the end of a row sits in the column of the last bin
    a_row_done_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_row_done |->
            i_column == sphd_pkg::COL_W'(sphd_pkg::LAST_BIN_COL))
        else $error("row end on wrong column");

    // level stays inside floor and ceiling
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_level >= $signed(sphd_pkg::LVL_W'(sphd_pkg::LEVEL_MIN))) &&
            (i_level <= $signed(sphd_pkg::LVL_W'(sphd_pkg::LEVEL_MAX))))
        else $error("level out of range");

endmodule

bind spectrum_peak_hold_db sphd_checker u_sphd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_bin.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_column    (o_res.column),
    .i_level     (o_res.level),
    .i_row_done  (o_res.row_done)
);
